@@ rtl/swrb_pkg.sv @@
`timescale 1ns / 1ps

package swrb_pkg;

  // Default window geometry.
  localparam int LOOKBACK_DEF      = 30;
  localparam int MAX_EMBED_DIM_DEF = 8;

  // Fixed field widths.
  localparam int SAMPLE_W = 32;
  localparam int RADIUS_W = 32;
  localparam int DIM_W    = 4;
  localparam int DLY_W    = 5;
  localparam int COMP_W   = 5;
  localparam int RANK_W   = 9;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_EMBED_DIM   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_RADIUS = 2'd2;

  // Register reset values.
  localparam logic [DIM_W-1:0] DIM_RST = 4'd3;
  localparam logic [DLY_W-1:0] DLY_RST = 5'd1;

  // Operation of the shared shift-and-add unit.
  typedef enum logic {
    ITER_MUL,
    ITER_DIV
  } iter_mode_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_AD_DIST,
    S_AD_WAIT,
    S_AD_SQRT,
    S_DIV_WAIT,
    S_THR_WAIT,
    S_PR_DIST,
    S_PR_WAIT,
    S_BFS_PICK,
    S_BFS_GROW,
    S_OUT
  } state_t;

endpackage

@@ rtl/swrb_dist.sv @@
`timescale 1ns / 1ps

// Sample store and squared-distance engine. One coordinate pair enters per
// cycle; read, difference, square and accumulate are separate stages.
module swrb_dist #(
  parameter int DEPTH   = swrb_pkg::LOOKBACK_DEF + 1,
  parameter int MAX_DIM = swrb_pkg::MAX_EMBED_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic [swrb_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                          start,
  input  logic [$clog2(DEPTH)-1:0]      head,
  input  logic [$clog2(DEPTH)-1:0]      pa,
  input  logic [$clog2(DEPTH)-1:0]      pb,
  input  logic [swrb_pkg::DIM_W-1:0]    dim,
  input  logic [swrb_pkg::DLY_W-1:0]    dly,
  output logic                          done,
  output logic [64+$clog2(MAX_DIM)-1:0] dist_sum
);

  localparam int AW    = $clog2(DEPTH);
  localparam int DCW   = $clog2(MAX_DIM + 1);
  localparam int ACC_W = 64 + $clog2(MAX_DIM);
  localparam int SW    = swrb_pkg::SAMPLE_W;

  logic [SW-1:0] mem [DEPTH];

  logic [DCW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]    offa_r, offa_nxt, offb_r, offb_nxt;
  logic             s1_v_r, s1_v_nxt, s1_last_r, s1_last_nxt;
  logic [SW-1:0]    rda_r, rdb_r;
  logic             s2_v_r, s2_last_r;
  logic [SW-1:0]    mag_r, mag_nxt;
  logic             s3_v_r, s3_last_r;
  logic [2*SW-1:0]  prod_r;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             done_r;
  logic [SW:0]      diff;

  // Logical age k maps to the slot k places behind the newest sample.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] k);
    logic [AW:0] t;
    t = {1'b0, h} - {1'b0, k};
    if (t[AW]) begin
      t = t + (AW+1)'(DEPTH);
    end
    return t[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rda_r <= mem[phys(head, offa_r)];
    rdb_r <= mem[phys(head, offb_r)];
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    offa_nxt    = offa_r;
    offb_nxt    = offb_r;
    s1_v_nxt    = 1'b0;
    s1_last_nxt = 1'b0;
    acc_nxt     = acc_r;
    if (start) begin
      cnt_nxt  = DCW'(dim);
      offa_nxt = pa;
      offb_nxt = pb;
      acc_nxt  = '0;
    end else begin
      if (cnt_r != '0) begin
        cnt_nxt     = cnt_r - DCW'(1);
        offa_nxt    = offa_r + AW'(dly);
        offb_nxt    = offb_r + AW'(dly);
        s1_v_nxt    = 1'b1;
        s1_last_nxt = (cnt_r == DCW'(1));
      end
      if (s3_v_r) begin
        acc_nxt = acc_r + ACC_W'(prod_r);
      end
    end
    diff    = $signed({rda_r[SW-1], rda_r}) - $signed({rdb_r[SW-1], rdb_r});
    mag_nxt = diff[SW] ? SW'(-diff) : diff[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      s1_v_r    <= 1'b0;
      s1_last_r <= 1'b0;
      s2_v_r    <= 1'b0;
      s2_last_r <= 1'b0;
      s3_v_r    <= 1'b0;
      s3_last_r <= 1'b0;
      done_r    <= 1'b0;
      acc_r     <= '0;
    end else begin
      cnt_r     <= cnt_nxt;
      s1_v_r    <= s1_v_nxt;
      s1_last_r <= s1_last_nxt;
      s2_v_r    <= s1_v_r;
      s2_last_r <= s1_last_r;
      s3_v_r    <= s2_v_r;
      s3_last_r <= s2_last_r;
      done_r    <= s3_v_r && s3_last_r;
      acc_r     <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    offa_r <= offa_nxt;
    offb_r <= offb_nxt;
    mag_r  <= mag_nxt;
    prod_r <= mag_r * mag_r;
  end

  assign done     = done_r;
  assign dist_sum = acc_r;

endmodule

@@ rtl/swrb_sqrt.sv @@
`timescale 1ns / 1ps

// Digit-by-digit integer square root, one result bit per cycle.
module swrb_sqrt #(
  parameter int IN_W = 67
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [IN_W-1:0]       radicand,
  output logic                  done,
  output logic [(IN_W+1)/2-1:0] root
);

  localparam int R     = (IN_W + 1) / 2;
  localparam int CNT_W = $clog2(R + 1);

  logic [2*R-1:0] x_r, x_nxt;
  logic [R+1:0]   rem_r, rem_nxt;
  logic [R-1:0]   root_r, root_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic           done_nxt, done_r;
  logic [R+3:0]   rem2, trial;
  logic           ge;

  always_comb begin
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem2     = {rem_r, x_r[2*R-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    ge       = rem2 >= trial;
    if (start) begin
      x_nxt    = (2*R)'(radicand);
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(R);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? (R+2)'(rem2 - trial) : rem2[R+1:0];
      root_nxt = {root_r[R-2:0], ge};
      x_nxt    = {x_r[2*R-3:0], 2'b00};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

@@ rtl/swrb_iter.sv @@
`timescale 1ns / 1ps

// Shared shift-and-add unit: serial multiply or restoring divide, one bit
// per cycle through a single adder.
module swrb_iter #(
  parameter int W = 40
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  swrb_pkg::iter_mode_t mode,
  input  logic [W-1:0]         op_a,
  input  logic [W-1:0]         op_b,
  output logic                 done,
  output logic [2*W-1:0]       result
);

  localparam int CNT_W = $clog2(W + 1);

  swrb_pkg::iter_mode_t mode_r, mode_nxt;
  logic [W-1:0]     hi_r, hi_nxt, lo_r, lo_nxt, y_r, y_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [W:0]       rdiv, add_a, add_b;
  logic             cin;
  logic [W+1:0]     sum;

  always_comb begin
    mode_nxt = mode_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    y_nxt    = y_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rdiv     = {hi_r, lo_r[W-1]};
    if (mode_r == swrb_pkg::ITER_MUL) begin
      add_a = {1'b0, hi_r};
      add_b = lo_r[0] ? {1'b0, y_r} : '0;
      cin   = 1'b0;
    end else begin
      add_a = rdiv;
      add_b = ~{1'b0, y_r};
      cin   = 1'b1;
    end
    sum = {1'b0, add_a} + {1'b0, add_b} + (W+2)'(cin);
    if (start) begin
      mode_nxt = mode;
      hi_nxt   = '0;
      if (mode == swrb_pkg::ITER_MUL) begin
        lo_nxt = op_b;
        y_nxt  = op_a;
      end else begin
        lo_nxt = op_a;
        y_nxt  = op_b;
      end
      cnt_nxt = CNT_W'(W);
    end else if (cnt_r != '0) begin
      if (mode_r == swrb_pkg::ITER_MUL) begin
        hi_nxt = sum[W:1];
        lo_nxt = {sum[0], lo_r[W-1:1]};
      end else begin
        // Carry out means the trial subtraction did not borrow.
        hi_nxt = sum[W+1] ? sum[W-1:0] : rdiv[W-1:0];
        lo_nxt = {lo_r[W-2:0], sum[W+1]};
      end
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
      mode_r <= swrb_pkg::ITER_MUL;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    y_r  <= y_nxt;
  end

  assign done   = done_r;
  assign result = {hi_r, lo_r};

endmodule

@@ rtl/sliding_window_rips_betti_core.sv @@
`timescale 1ns / 1ps

// Sliding-window neighbor-graph Betti counter.
// Input channel: in_valid / in_stall carry one signed Q16.16 price sample per
// transaction. in_stall is high whenever the block is working on a sample, so
// one sample is processed at a time.
// Output channel: out_valid / out_stall carry one result transaction per
// sample: component count, cycle rank, window-full and config-error flags.
// The result sits in an output register; a new sample is accepted while it
// waits, and a stalled result holds until the receiver takes it.
// Configuration: cfg_valid / cfg_ready write one register per transaction
// (0 embedding dimension, 1 delay step, 2 link radius); cfg_ready is always
// high and writes are expected only while the block is idle.
// Flow: while the window is filling or the settings are bad the result goes
// straight to the output. With a full window each point pair passes through
// the distance pipeline; an adaptive radius also takes a square root per
// consecutive pair and then the radius divide and square; labeling then steps
// through each point and each graph level. The distance pipeline and its
// single multiplier take most of a full run.
// Reset: synchronous, active low; registers return to their reset values,
// the sample count clears and no result is pending.
module sliding_window_rips_betti_core #(
  parameter int LOOKBACK      = swrb_pkg::LOOKBACK_DEF,
  parameter int MAX_EMBED_DIM = swrb_pkg::MAX_EMBED_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [swrb_pkg::SAMPLE_W-1:0] in_price_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [swrb_pkg::COMP_W-1:0]    out_component_count,
  output logic [swrb_pkg::RANK_W-1:0]    out_cycle_rank,
  output logic                           out_window_full,
  output logic                           out_config_error,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [swrb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swrb_pkg::RADIUS_W-1:0]  cfg_data
);

  localparam int DEPTH  = LOOKBACK + 1;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int EW     = $clog2(DEPTH * (DEPTH - 1) / 2 + 1);
  localparam int ACC_W  = 64 + $clog2(MAX_EMBED_DIM);
  localparam int ROOT_W = (ACC_W + 1) / 2;
  localparam int SUM_W  = ROOT_W + $clog2(DEPTH);
  localparam int EPS_W  = SUM_W + 1;
  localparam int THR_W  = 2 * EPS_W;
  localparam int DIM_W  = swrb_pkg::DIM_W;
  localparam int DLY_W  = swrb_pkg::DLY_W;
  localparam int COMP_W = swrb_pkg::COMP_W;
  localparam int RANK_W = swrb_pkg::RANK_W;
  localparam int SPAN_W = DIM_W + DLY_W;

  swrb_pkg::state_t state_r, state_nxt;

  // Configuration registers.
  logic [DIM_W-1:0]              dim_r, dim_nxt;
  logic [DLY_W-1:0]              dly_r, dly_nxt;
  logic [swrb_pkg::RADIUS_W-1:0] rad_r, rad_nxt;

  // Window bookkeeping.
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] seen_r, seen_nxt;

  // Per-sample working state.
  logic             full_r, full_nxt, bad_r, bad_nxt, ok_r, ok_nxt;
  logic [CW-1:0]    npts_r, npts_nxt, i_r, i_nxt, j_r, j_nxt, comps_r, comps_nxt;
  logic [EW-1:0]    edges_r, edges_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [THR_W-1:0] thr_r, thr_nxt;
  logic [DEPTH-1:0] adj_r [DEPTH];
  logic [DEPTH-1:0] seen_v_r, seen_v_nxt, front_r, front_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [COMP_W-1:0] out_comp_r, out_comp_nxt;
  logic [RANK_W-1:0] out_rank_r, out_rank_nxt;
  logic              out_full_r, out_full_nxt, out_err_r, out_err_nxt;

  // Unit handshakes.
  logic                 in_acc, wr_en;
  logic                 dist_start, dist_done;
  logic [AW-1:0]        dist_pa, dist_pb;
  logic [ACC_W-1:0]     dist_val;
  logic                 sqrt_start, sqrt_done;
  logic [ROOT_W-1:0]    sqrt_root;
  logic                 iter_start, iter_done;
  swrb_pkg::iter_mode_t iter_mode;
  logic [EPS_W-1:0]     iter_a, iter_b;
  logic [THR_W-1:0]     iter_res;
  logic                 adj_clr, edge_set;

  // Combinational helpers.
  logic [SPAN_W-1:0] span;
  logic              full_v, bad_v;
  logic [EPS_W+1:0]  eps3;
  logic [DEPTH-1:0]  reach, fnew, onehot;
  logic [EW:0]       tot;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != swrb_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    dim_nxt       = dim_r;
    dly_nxt       = dly_r;
    rad_nxt       = rad_r;
    head_nxt      = head_r;
    seen_nxt      = seen_r;
    full_nxt      = full_r;
    bad_nxt       = bad_r;
    ok_nxt        = ok_r;
    npts_nxt      = npts_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    comps_nxt     = comps_r;
    edges_nxt     = edges_r;
    sum_nxt       = sum_r;
    thr_nxt       = thr_r;
    seen_v_nxt    = seen_v_r;
    front_nxt     = front_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_comp_nxt  = out_comp_r;
    out_rank_nxt  = out_rank_r;
    out_full_nxt  = out_full_r;
    out_err_nxt   = out_err_r;
    wr_en         = 1'b0;
    dist_start    = 1'b0;
    dist_pa       = i_r[AW-1:0];
    dist_pb       = j_r[AW-1:0];
    sqrt_start    = 1'b0;
    iter_start    = 1'b0;
    iter_mode     = swrb_pkg::ITER_MUL;
    iter_a        = EPS_W'(rad_r);
    iter_b        = EPS_W'(rad_r);
    adj_clr       = 1'b0;
    edge_set      = 1'b0;

    span   = SPAN_W'(dim_r - DIM_W'(1)) * SPAN_W'(dly_r);
    full_v = (seen_r == CW'(DEPTH));
    bad_v  = (dim_r == '0) || ((DIM_W+1)'(dim_r) > (DIM_W+1)'(MAX_EMBED_DIM)) ||
             (dly_r == '0) || ((SPAN_W+1)'(span) > (SPAN_W+1)'(LOOKBACK - 1));
    eps3   = {2'b00, iter_res[EPS_W-1:0]} + {1'b0, iter_res[EPS_W-1:0], 1'b0};
    onehot = DEPTH'(1) << i_r[AW-1:0];
    reach  = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (front_r[k]) begin
        reach = reach | adj_r[k];
      end
    end
    fnew = reach & ~seen_v_r;
    tot  = (EW+1)'(edges_r) + (EW+1)'(comps_r);

    // Register writes; an index past the list is ignored.
    if (cfg_valid) begin
      case (cfg_index)
        swrb_pkg::CFG_EMBED_DIM:   dim_nxt = cfg_data[DIM_W-1:0];
        swrb_pkg::CFG_DELAY_STEP:  dly_nxt = cfg_data[DLY_W-1:0];
        swrb_pkg::CFG_LINK_RADIUS: rad_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      swrb_pkg::S_IDLE: begin
        if (in_acc) begin
          head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
          wr_en     = 1'b1;
          if (seen_r != CW'(DEPTH)) begin
            seen_nxt = seen_r + CW'(1);
          end
          state_nxt = swrb_pkg::S_CHECK;
        end
      end
      swrb_pkg::S_CHECK: begin
        full_nxt  = full_v;
        bad_nxt   = bad_v;
        ok_nxt    = full_v && !bad_v;
        npts_nxt  = CW'(DEPTH) - CW'(span);
        comps_nxt = '0;
        edges_nxt = '0;
        sum_nxt   = '0;
        i_nxt     = '0;
        j_nxt     = CW'(1);
        adj_clr   = 1'b1;
        if (!(full_v && !bad_v)) begin
          state_nxt = swrb_pkg::S_OUT;
        end else if (rad_r != '0) begin
          iter_start = 1'b1;
          state_nxt  = swrb_pkg::S_THR_WAIT;
        end else begin
          state_nxt = swrb_pkg::S_AD_DIST;
        end
      end
      swrb_pkg::S_AD_DIST: begin
        dist_start = 1'b1;
        dist_pb    = AW'(i_r + CW'(1));
        state_nxt  = swrb_pkg::S_AD_WAIT;
      end
      swrb_pkg::S_AD_WAIT: begin
        if (dist_done) begin
          sqrt_start = 1'b1;
          state_nxt  = swrb_pkg::S_AD_SQRT;
        end
      end
      swrb_pkg::S_AD_SQRT: begin
        if (sqrt_done) begin
          sum_nxt = sum_r + SUM_W'(sqrt_root);
          if (i_r + CW'(2) == npts_r) begin
            // Mean consecutive distance: sum over the npts-1 links.
            iter_start = 1'b1;
            iter_mode  = swrb_pkg::ITER_DIV;
            iter_a     = EPS_W'(sum_nxt);
            iter_b     = EPS_W'(npts_r - CW'(1));
            state_nxt  = swrb_pkg::S_DIV_WAIT;
          end else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = swrb_pkg::S_AD_DIST;
          end
        end
      end
      swrb_pkg::S_DIV_WAIT: begin
        if (iter_done) begin
          // Radius is 1.5 times the mean, rounded down, then squared.
          iter_start = 1'b1;
          iter_a     = eps3[EPS_W:1];
          iter_b     = eps3[EPS_W:1];
          state_nxt  = swrb_pkg::S_THR_WAIT;
        end
      end
      swrb_pkg::S_THR_WAIT: begin
        if (iter_done) begin
          thr_nxt   = iter_res;
          i_nxt     = '0;
          j_nxt     = CW'(1);
          state_nxt = swrb_pkg::S_PR_DIST;
        end
      end
      swrb_pkg::S_PR_DIST: begin
        dist_start = 1'b1;
        state_nxt  = swrb_pkg::S_PR_WAIT;
      end
      swrb_pkg::S_PR_WAIT: begin
        if (dist_done) begin
          if (THR_W'(dist_val) <= thr_r) begin
            edge_set  = 1'b1;
            edges_nxt = edges_r + EW'(1);
          end
          if (j_r == npts_r - CW'(1)) begin
            if (i_r == npts_r - CW'(2)) begin
              i_nxt      = '0;
              seen_v_nxt = '0;
              state_nxt  = swrb_pkg::S_BFS_PICK;
            end else begin
              i_nxt     = i_r + CW'(1);
              j_nxt     = i_r + CW'(2);
              state_nxt = swrb_pkg::S_PR_DIST;
            end
          end else begin
            j_nxt     = j_r + CW'(1);
            state_nxt = swrb_pkg::S_PR_DIST;
          end
        end
      end
      swrb_pkg::S_BFS_PICK: begin
        if (i_r == npts_r) begin
          state_nxt = swrb_pkg::S_OUT;
        end else if (seen_v_r[i_r[AW-1:0]]) begin
          i_nxt = i_r + CW'(1);
        end else begin
          comps_nxt  = comps_r + CW'(1);
          front_nxt  = onehot;
          seen_v_nxt = seen_v_r | onehot;
          state_nxt  = swrb_pkg::S_BFS_GROW;
        end
      end
      swrb_pkg::S_BFS_GROW: begin
        // Expand the component one graph level per cycle.
        front_nxt  = fnew;
        seen_v_nxt = seen_v_r | fnew;
        if (fnew == '0) begin
          state_nxt = swrb_pkg::S_BFS_PICK;
        end
      end
      swrb_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_full_nxt  = full_r;
          out_err_nxt   = bad_r;
          out_comp_nxt  = ok_r ? COMP_W'(comps_r) : '0;
          out_rank_nxt  = (ok_r && (tot > (EW+1)'(npts_r))) ?
                          RANK_W'(tot - (EW+1)'(npts_r)) : '0;
          state_nxt     = swrb_pkg::S_IDLE;
        end
      end
      default: state_nxt = swrb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swrb_pkg::S_IDLE;
      dim_r       <= swrb_pkg::DIM_RST;
      dly_r       <= swrb_pkg::DLY_RST;
      rad_r       <= '0;
      head_r      <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dim_r       <= dim_nxt;
      dly_r       <= dly_nxt;
      rad_r       <= rad_nxt;
      head_r      <= head_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    full_r     <= full_nxt;
    bad_r      <= bad_nxt;
    ok_r       <= ok_nxt;
    npts_r     <= npts_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    comps_r    <= comps_nxt;
    edges_r    <= edges_nxt;
    sum_r      <= sum_nxt;
    thr_r      <= thr_nxt;
    seen_v_r   <= seen_v_nxt;
    front_r    <= front_nxt;
    out_comp_r <= out_comp_nxt;
    out_rank_r <= out_rank_nxt;
    out_full_r <= out_full_nxt;
    out_err_r  <= out_err_nxt;
  end

  // Adjacency rows: cleared at the start of each run, edges set symmetrically.
  always_ff @(posedge clk) begin
    if (adj_clr) begin
      for (int k = 0; k < DEPTH; k++) begin
        adj_r[k] <= '0;
      end
    end else if (edge_set) begin
      adj_r[i_r[AW-1:0]][j_r[AW-1:0]] <= 1'b1;
      adj_r[j_r[AW-1:0]][i_r[AW-1:0]] <= 1'b1;
    end
  end

  swrb_dist #(
    .DEPTH   (DEPTH),
    .MAX_DIM (MAX_EMBED_DIM)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (head_nxt),
    .wr_data  (in_price_sample),
    .start    (dist_start),
    .head     (head_r),
    .pa       (dist_pa),
    .pb       (dist_pb),
    .dim      (dim_r),
    .dly      (dly_r),
    .done     (dist_done),
    .dist_sum (dist_val)
  );

  swrb_sqrt #(
    .IN_W (ACC_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (dist_val),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  swrb_iter #(
    .W (EPS_W)
  ) u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (iter_start),
    .mode   (iter_mode),
    .op_a   (iter_a),
    .op_b   (iter_b),
    .done   (iter_done),
    .result (iter_res)
  );

  assign out_valid           = out_valid_r;
  assign out_component_count = out_comp_r;
  assign out_cycle_rank      = out_rank_r;
  assign out_window_full     = out_full_r;
  assign out_config_error    = out_err_r;

endmodule

@@ tb/sv/swrb_checker.sv @@
`timescale 1ns / 1ps

module swrb_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic signed [swrb_pkg::SAMPLE_W-1:0] in_price_sample,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [swrb_pkg::COMP_W-1:0]    out_component_count,
  input  logic [swrb_pkg::RANK_W-1:0]    out_cycle_rank,
  input  logic                           out_window_full,
  input  logic                           out_config_error,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [swrb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swrb_pkg::RADIUS_W-1:0]  cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import swrb_pkg::*;

  localparam int DEPTH = LOOKBACK_DEF + 1;

  typedef struct packed {
    logic [COMP_W-1:0] comps;
    logic [RANK_W-1:0] rank;
    logic              full;
    logic              bad;
  } betti_t;

  betti_t             betti_q[$];
  longint             hist[DEPTH];
  int                 seen_cnt;
  logic [DIM_W-1:0]   dim_reg;
  logic [DLY_W-1:0]   dly_reg;
  logic [RADIUS_W-1:0] radius_reg;

  function automatic logic [127:0] pair_dist(int a, int b, int dim, int dly);
    logic [127:0] acc;
    longint diff;
    longint unsigned mag;
    acc = '0;
    for (int d = 0; d < dim; d++) begin
      diff = hist[a + d * dly] - hist[b + d * dly];
      mag = (diff < 0) ? longint'(-diff) : longint'(diff);
      acc = acc + {64'd0, mag * mag};
    end
    return acc;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [127:0] x);
    logic [63:0] res;
    logic [63:0] cand;
    res = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = res | (64'd1 << i);
      if (({64'd0, cand} * {64'd0, cand}) <= x) res = cand;
    end
    return res;
  endfunction

  function automatic betti_t betti_of_window();
    betti_t r;
    int dim, dly, npts, edges, comps;
    logic [127:0] thr;
    logic [63:0] sum, eps;
    logic [DEPTH-1:0] adj[DEPTH];
    logic [DEPTH-1:0] visited, front, nxt;
    dim = int'(dim_reg);
    dly = int'(dly_reg);
    r = '0;
    r.full = (seen_cnt >= DEPTH);
    r.bad = (dim == 0) || (dim > MAX_EMBED_DIM_DEF) || (dly == 0) ||
            ((dim - 1) * dly > LOOKBACK_DEF - 1);
    if (!r.full || r.bad) return r;
    npts = DEPTH - (dim - 1) * dly;
    if (radius_reg != 0) begin
      thr = {96'd0, radius_reg} * {96'd0, radius_reg};
    end else begin
      // Adaptive radius: 1.5 times the mean consecutive-point distance.
      sum = '0;
      for (int k = 0; k + 1 < npts; k++) sum = sum + floor_sqrt(pair_dist(k, k + 1, dim, dly));
      eps = sum / 64'(npts - 1);
      eps = eps * 3 / 2;
      thr = {64'd0, eps} * {64'd0, eps};
    end
    edges = 0;
    for (int i = 0; i < DEPTH; i++) adj[i] = '0;
    for (int i = 0; i < npts; i++) begin
      for (int j = i + 1; j < npts; j++) begin
        if (pair_dist(i, j, dim, dly) <= thr) begin
          adj[i][j] = 1'b1;
          adj[j][i] = 1'b1;
          edges++;
        end
      end
    end
    comps = 0;
    visited = '0;
    for (int i = 0; i < npts; i++) begin
      if (!visited[i]) begin
        comps++;
        front = '0;
        front[i] = 1'b1;
        visited[i] = 1'b1;
        while (front != 0) begin
          nxt = '0;
          for (int j = 0; j < npts; j++) if (front[j]) nxt = nxt | adj[j];
          front = nxt & ~visited;
          visited = visited | front;
        end
      end
    end
    r.comps = comps[COMP_W-1:0];
    if (edges + comps > npts) r.rank = 9'(edges + comps - npts);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    betti_t want;
    if (!rst_n) begin
      betti_q.delete();
      for (int i = 0; i < DEPTH; i++) hist[i] = 0;
      seen_cnt = 0;
      dim_reg = DIM_RST;
      dly_reg = DLY_RST;
      radius_reg = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_EMBED_DIM:   dim_reg = cfg_data[DIM_W-1:0];
          CFG_DELAY_STEP:  dly_reg = cfg_data[DLY_W-1:0];
          CFG_LINK_RADIUS: radius_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        for (int i = DEPTH - 1; i > 0; i--) hist[i] = hist[i - 1];
        hist[0] = longint'(in_price_sample);
        if (seen_cnt < DEPTH) seen_cnt++;
        betti_q.insert(betti_q.size(), betti_of_window());
      end
      if (out_valid && !out_stall) begin
        if (betti_q.size() == 0) begin
          report_mismatch("unexpected result, queue size", 1, 0);
        end else begin
          want = betti_q.pop_front();
          if (out_component_count !== want.comps)
            report_mismatch("component_count", out_component_count, want.comps);
          if (out_cycle_rank !== want.rank)
            report_mismatch("cycle_rank", out_cycle_rank, want.rank);
          if (out_window_full !== want.full)
            report_mismatch("window_full", out_window_full, want.full);
          if (out_config_error !== want.bad)
            report_mismatch("config_error", out_config_error, want.bad);
        end
      end
    end
    pending = betti_q.size();
  end

endmodule

@@ tb/sv/sliding_window_rips_betti_core_tb.sv @@
`timescale 1ns / 1ps

// Top of the testbench. It makes the clock and reset, drives the sample,
// result-stall and configuration channels, and gives the verdict. All
// prediction and comparison live in the checker instantiated beside the core.
module sliding_window_rips_betti_core_tb;
  import swrb_pkg::*;

  // Index past the last register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  // Cycle limit for the whole run, with stalls and gaps included.
  localparam int CYCLE_LIMIT = 6000000;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [SAMPLE_W-1:0] in_price_sample;
  logic                    out_valid;
  logic                    out_stall;
  logic [COMP_W-1:0]       out_component_count;
  logic [RANK_W-1:0]       out_cycle_rank;
  logic                    out_window_full;
  logic                    out_config_error;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [RADIUS_W-1:0]     cfg_data;
  int                      fail_count;
  int                      pending;
  int                      cycle_cnt;
  int                      stall_hold;
  logic [SAMPLE_W-1:0]     walk_val;

  sliding_window_rips_betti_core u_top (.*);

  swrb_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The receiver stalls in runs: mostly short bursts, now and then a long
  // one, and stretches where it takes every result at once.
  always @(negedge clk) begin
    int pick;
    if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        out_stall = 1'b0;
        stall_hold = $urandom_range(0, 20);
      end else if (pick < 95) begin
        out_stall = 1'b1;
        stall_hold = $urandom_range(0, 3);
      end else begin
        out_stall = 1'b1;
        stall_hold = $urandom_range(20, 200);
      end
    end
  end

  // Present one sample and hold it until the core takes the transaction,
  // then idle for a random gap. With no gap, valid simply stays high.
  task automatic send_sample(logic [SAMPLE_W-1:0] value);
    int pick;
    int gap;
    in_price_sample = value;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    pick = $urandom_range(0, 99);
    gap = (pick < 50) ? 0 : (pick < 92) ? $urandom_range(1, 4) : $urandom_range(50, 300);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Registers may only change while the core is idle, so the sender stops
  // and waits until every outstanding result has been taken.
  task automatic drain();
    in_valid = 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [RADIUS_W-1:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_embedding(int dim, int dly, logic [RADIUS_W-1:0] radius);
    drain();
    cfg_write(CFG_EMBED_DIM, RADIUS_W'(dim));
    cfg_write(CFG_DELAY_STEP, RADIUS_W'(dly));
    cfg_write(CFG_LINK_RADIUS, radius);
  endtask

  // Random samples: full-range noise, a slow random walk that gives the
  // neighbor graph real structure, repeated values and the extremes.
  function automatic logic [SAMPLE_W-1:0] next_sample();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      walk_val = $urandom;
      return walk_val;
    end else if (pick < 85) begin
      walk_val = walk_val + SAMPLE_W'($urandom_range(0, 131072)) - 32'd65536;
      return walk_val;
    end else if (pick < 93) begin
      return walk_val;
    end
    return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  initial begin
    int dim, dly;
    logic [RADIUS_W-1:0] radius;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_price_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_EMBED_DIM;
    cfg_data = '0;
    walk_val = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part at the reset settings: field extremes while the window
    // fills, then a rising ramp and a constant tail of repeated samples.
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0001);
    send_sample(32'h0001_0000);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    for (int i = 0; i < 16; i++) send_sample(32'h0001_0000 + 32'(i * 'h4000));
    for (int i = 0; i < 8; i++) send_sample(32'h0002_0000);

    // Random phases, each under new settings including the extremes and
    // every kind of unusable embedding. Each phase begins with a drain.
    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: begin dim = 8; dly = 4; radius = '0; end
        1: begin dim = 1; dly = 1; radius = 32'h0000_8000; end
        2: begin dim = 2; dly = 29; radius = 32'hFFFF_FFFF; end
        3: begin dim = 0; dly = 1; radius = '0; end
        4: begin dim = 15; dly = 0; radius = 32'h0000_0001; end
        5: begin dim = 8; dly = 5; radius = '0; end
        6: begin dim = 3; dly = 1; radius = 32'h0002_0000; end
        default: begin
          dim = $urandom_range(1, 8);
          dly = $urandom_range(1, 29 / ((dim > 1) ? dim - 1 : 1));
          radius = ($urandom_range(0, 1) != 0) ? '0 : RADIUS_W'($urandom_range(1, 'h40000));
        end
      endcase
      set_embedding(dim, dly, radius);
      if (phase == 4) cfg_write(CFG_UNUSED_IDX, $urandom);
      for (int i = 0; i < 8; i++) send_sample(next_sample());
    end
    set_embedding(3, 1, '0);
    for (int i = 0; i < 10; i++) send_sample(next_sample());

    // Let the last results drain, then allow a short settling margin.
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
